FILE: hw/rtl/afp_pkg.sv
// Shared types and constants of the animation frame playhead.
`timescale 1ns / 1ps
`default_nettype none
package afp_pkg;

    localparam int FRAME_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_W             = 16;
    localparam int TIME_W            = 20;
    localparam int PROD_W            = CFG_W + TIME_W;
    localparam int ADDR_W            = 5;

    localparam logic [CFG_W-1:0] SPEED_RESET = 16'd7680;  // 30.0 frames/s in 8.8

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_FRAME_COUNT = 3'd0;
    localparam logic [2:0] REG_START_LIMIT = 3'd1;
    localparam logic [2:0] REG_END_LIMIT   = 3'd2;
    localparam logic [2:0] REG_LIMITS_ON   = 3'd3;
    localparam logic [2:0] REG_LOOP_ON     = 3'd4;
    localparam logic [2:0] REG_PLAY_SPEED  = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0] frame_count;
        logic [CFG_W-1:0] start_limit;
        logic [CFG_W-1:0] end_limit;
        logic             limits_on;
        logic             loop_on;
        logic [CFG_W-1:0] play_speed;
    } t_cfg;

    // copy of the range inputs taken at the last write that set a range
    typedef struct packed {
        logic [CFG_W-1:0] frame_count;
        logic [CFG_W-1:0] start_limit;
        logic [CFG_W-1:0] end_limit;
        logic             limits_on;
    } t_lim;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIM_S,
        S_LIM_SW,
        S_LIM_E,
        S_LIM_EW,
        S_MUL,
        S_ADD,
        S_WRAP,
        S_WRAPW,
        S_NEXT,
        S_NEXTW,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

FILE: hw/rtl/animation_frame_playhead_top.sv
// Top level of the animation frame playhead: sequencer, position datapath, ports.
`timescale 1ns / 1ps
`default_nettype none
// Keyframe playback cursor. Each transaction on the s_axis side is one elapsed-time
// tick (4.16 seconds); the block advances a FRAME_BITS.FRACTION_BITS frame position
// by play_speed * elapsed_time, wraps it into the start..end range when looping or
// clamps it at the end frame otherwise, and returns one m_axis transaction with the
// current frame, the next frame and the 0.16 blend fraction between them. All
// remainders (range limits modulo frame_count, loop wrap, next-frame wrap) go through
// a single shared restoring remainder unit, DW = max(FRAME_BITS,16) bits wide. A
// tick steps through the multiply, add, wrap, next-frame and output states, plus one
// remainder pass when the position wraps and one when the next frame runs past
// frame_count, waits in the output state while m_axis is held off, and goes back to
// idle before the next tick is taken. The first tick after a write to frame_count,
// start_limit, end_limit or limits_on with a nonzero frame_count also recomputes the
// effective range first, with one remainder pass each for start and end with limits on.
// s_axis_tready is low while a tick is in work; config writes belong to idle time.
// Registers (byte address): 0x00 frame_count, 0x04 start_limit, 0x08 end_limit,
// 0x0C limits_on, 0x10 loop_on, 0x14 play_speed (8.8 frames/s, reset 30.0).
module animation_frame_playhead_top #(
    parameter int FRAME_BITS    = afp_pkg::FRAME_BITS_DEF,
    parameter int FRACTION_BITS = afp_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // stream in
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [23:0]                s_axis_tdata,   // [19:0] elapsed_time
    // stream out
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [55:0]                     m_axis_tdata,   // [15:0] frame_index,
                                                            // [31:16] next_frame_index,
                                                            // [47:32] blend_fraction,
                                                            // [48] at_end
    output logic                            m_axis_tuser,   // [0] valid_res
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [afp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import afp_pkg::*;

    localparam int FB     = FRAME_BITS;
    localparam int XB     = FRACTION_BITS;
    localparam int PW     = FB + XB;                     // position width
    localparam int DIV_W  = (FB > CFG_W) ? FB : CFG_W;   // remainder unit width
    localparam int IW     = PROD_W + XB;
    localparam int INC_W  = IW - 24;                     // 12.24 product cut to XB fraction bits
    localparam int EW     = ((INC_W > PW) ? INC_W : PW) + 1;
    localparam logic [EW-1:0] POS_MAX = {{(EW - PW){1'b0}}, {PW{1'b1}}};
    localparam logic [DIV_W-1:0] INT_MAX = DIV_W'({FB{1'b1}});

    t_cfg   cfg;
    t_lim   snap;
    logic   lim_dirty;
    logic   lim_done;
    t_state r_state, n_state;

    // shared remainder unit
    logic             div_start;
    logic [DIV_W-1:0] div_dvd;
    logic [DIV_W-1:0] div_dvs;
    logic             div_done;
    logic [DIV_W-1:0] div_rem;

    // datapath registers
    logic [TIME_W-1:0] r_dt;
    logic [PROD_W-1:0] r_prod;
    logic [PW-1:0]     r_pos;
    logic [FB-1:0]     r_rs;
    logic [FB-1:0]     r_re;
    logic [FB:0]       r_next;
    logic              r_clamp;
    logic              r_valid;

    afp_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_lim_done  (lim_done),
        .o_cfg       (cfg),
        .o_snap      (snap),
        .o_lim_dirty (lim_dirty)
    );

    afp_modunit #(.DW(DIV_W)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    function automatic logic [FB-1:0] sat_frame(input logic [DIV_W-1:0] v);
        sat_frame = (v > INT_MAX) ? INT_MAX[FB-1:0] : v[FB-1:0];
    endfunction

    // ---- combinational helpers on the current state
    logic [IW-1:0]    prod_wide;
    logic [INC_W-1:0] inc;
    logic [EW-1:0]    pos_sum;
    logic [FB-1:0]    pos_int;
    logic [XB-1:0]    pos_frac;
    logic [FB-1:0]    span;
    logic             span_nz;
    logic             past_end;
    logic [FB:0]      nxt;
    logic             nxt_wrap;
    logic             fc_nz;
    logic [DIV_W-1:0] fc_m1;

    assign prod_wide = {r_prod, {XB{1'b0}}};
    assign inc       = prod_wide[IW-1:24];
    assign pos_sum   = EW'(r_pos) + EW'(inc);
    assign pos_int   = r_pos[PW-1:XB];
    assign pos_frac  = r_pos[XB-1:0];
    assign span_nz   = r_re > r_rs;
    assign span      = span_nz ? (r_re - r_rs) : '0;
    assign past_end  = r_pos >= {r_re, {XB{1'b0}}};
    assign nxt       = {1'b0, pos_int} + (FB + 1)'(pos_frac != '0);
    assign fc_nz     = cfg.frame_count != '0;
    assign nxt_wrap  = (DIV_W + 1)'(nxt) >= (DIV_W + 1)'(cfg.frame_count);
    assign fc_m1     = DIV_W'(snap.frame_count) - DIV_W'(1);

    // ---- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) n_state = lim_dirty ? S_LIM_S : S_MUL;
            end
            S_LIM_S:  n_state = snap.limits_on ? S_LIM_SW : S_MUL;
            S_LIM_SW: if (div_done) n_state = S_LIM_E;
            S_LIM_E:  n_state = S_LIM_EW;
            S_LIM_EW: if (div_done) n_state = S_MUL;
            S_MUL:    n_state = S_ADD;
            S_ADD:    n_state = S_WRAP;
            S_WRAP: begin
                if (past_end && cfg.loop_on && span_nz) n_state = S_WRAPW;
                else                                     n_state = S_NEXT;
            end
            S_WRAPW:  if (div_done) n_state = S_NEXT;
            S_NEXT: begin
                if (fc_nz && nxt_wrap && span_nz) n_state = S_NEXTW;
                else                               n_state = S_OUT;
            end
            S_NEXTW:  if (div_done) n_state = S_OUT;
            S_OUT:    if (m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---- sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        lim_done      = 1'b0;
        div_start     = 1'b0;
        div_dvd       = '0;
        div_dvs       = '0;
        case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_LIM_S: begin
                div_start = snap.limits_on;
                div_dvd   = DIV_W'(snap.start_limit);
                div_dvs   = DIV_W'(snap.frame_count);
                lim_done  = !snap.limits_on;
            end
            S_LIM_E: begin
                div_start = 1'b1;
                div_dvd   = DIV_W'(snap.end_limit);
                div_dvs   = DIV_W'(snap.frame_count);
            end
            S_LIM_EW: lim_done = div_done;
            S_WRAP: begin
                // (pos - end) mod span works on the integer part, fraction rides along
                div_start = past_end && cfg.loop_on && span_nz;
                div_dvd   = DIV_W'(pos_int - r_re);
                div_dvs   = DIV_W'(span);
            end
            S_NEXT: begin
                div_start = fc_nz && nxt_wrap && span_nz;
                div_dvd   = DIV_W'(pos_int);
                div_dvs   = DIV_W'(span);
            end
            S_OUT: m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_rs    <= '0;
            r_re    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_LIM_S: begin
                    if (!snap.limits_on) begin
                        r_rs <= '0;
                        r_re <= sat_frame(fc_m1);
                    end
                end
                S_LIM_SW: if (div_done) r_rs <= sat_frame(div_rem);
                S_LIM_EW: if (div_done) r_re <= sat_frame(div_rem);
                S_ADD:    r_pos <= (pos_sum > POS_MAX) ? POS_MAX[PW-1:0] : pos_sum[PW-1:0];
                S_WRAP: begin
                    if (past_end) begin
                        if (!cfg.loop_on)  r_pos <= {r_re, {XB{1'b0}}};
                        else if (!span_nz) r_pos <= {r_rs, {XB{1'b0}}};
                    end
                end
                S_WRAPW: if (div_done) r_pos <= {r_rs + div_rem[FB-1:0], pos_frac};
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_dt    <= s_axis_tdata[TIME_W-1:0];
                r_clamp <= 1'b0;
            end
            S_MUL:  r_prod <= PROD_W'(cfg.play_speed) * PROD_W'(r_dt);
            S_WRAP: if (past_end && !cfg.loop_on) r_clamp <= 1'b1;
            S_NEXT: begin
                r_valid <= fc_nz;
                if (!nxt_wrap)     r_next <= nxt;
                else if (!span_nz) r_next <= {1'b0, r_rs};
            end
            S_NEXTW: if (div_done) r_next <= {1'b0, r_rs + div_rem[FB-1:0]};
            default: ;
        endcase
    end

    // ---- result formatting
    logic [15:0] out_idx;
    logic [15:0] out_next;
    logic [15:0] out_blend;

    assign out_idx  = 16'(DIV_W'(pos_int));
    assign out_next = 16'((DIV_W + 1)'(r_next));

    generate
        if (XB >= 16) begin : g_blend_cut
            assign out_blend = pos_frac[XB-1 -: 16];
        end else begin : g_blend_pad
            assign out_blend = {pos_frac, {(16 - XB){1'b0}}};
        end
    endgenerate

    assign m_axis_tdata = r_valid ? {7'd0, r_clamp, out_blend, out_next, out_idx} : '0;
    assign m_axis_tuser = r_valid;

endmodule
`default_nettype wire

FILE: hw/rtl/afp_modunit.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module afp_modunit #(
    parameter int DW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_rem
);
    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_dvd;
    logic [DW-1:0]    r_dvs;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    assign trial = {r_rem, r_dvd[DW-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

FILE: hw/rtl/afp_regs.sv
// Configuration register file with APB-style access and range snapshot.
`timescale 1ns / 1ps
`default_nettype none
module afp_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [afp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  wire logic                      i_lim_done,
    output afp_pkg::t_cfg                  o_cfg,
    output afp_pkg::t_lim                  o_snap,
    output logic                           o_lim_dirty
);
    import afp_pkg::*;

    logic [CFG_W-1:0] r_fc, r_start, r_end, r_speed;
    logic             r_lim_on, r_loop_on;
    logic [CFG_W-1:0] n_fc, n_start, n_end, n_speed;
    logic             n_lim_on, n_loop_on;
    t_lim             r_snap;
    logic             r_dirty;

    logic       wr;
    logic [2:0] idx;
    logic       range_wr;

    assign pready   = 1'b1;
    assign idx      = paddr[ADDR_W-1:2];
    assign wr       = psel && penable && pwrite;
    assign range_wr = wr && (idx == REG_FRAME_COUNT || idx == REG_START_LIMIT ||
                             idx == REG_END_LIMIT || idx == REG_LIMITS_ON);

    always_comb begin
        n_fc      = (wr && idx == REG_FRAME_COUNT) ? pwdata[CFG_W-1:0] : r_fc;
        n_start   = (wr && idx == REG_START_LIMIT) ? pwdata[CFG_W-1:0] : r_start;
        n_end     = (wr && idx == REG_END_LIMIT)   ? pwdata[CFG_W-1:0] : r_end;
        n_lim_on  = (wr && idx == REG_LIMITS_ON)   ? pwdata[0]         : r_lim_on;
        n_loop_on = (wr && idx == REG_LOOP_ON)     ? pwdata[0]         : r_loop_on;
        n_speed   = (wr && idx == REG_PLAY_SPEED)  ? pwdata[CFG_W-1:0] : r_speed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc      <= '0;
            r_start   <= '0;
            r_end     <= '0;
            r_lim_on  <= 1'b0;
            r_loop_on <= 1'b0;
            r_speed   <= SPEED_RESET;
            r_dirty   <= 1'b0;
        end else begin
            r_fc      <= n_fc;
            r_start   <= n_start;
            r_end     <= n_end;
            r_lim_on  <= n_lim_on;
            r_loop_on <= n_loop_on;
            r_speed   <= n_speed;
            // range only changes while a clip is loaded
            if (range_wr && n_fc != '0) begin
                r_dirty <= 1'b1;
            end else if (i_lim_done) begin
                r_dirty <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (range_wr && n_fc != '0) begin
            r_snap <= '{frame_count: n_fc, start_limit: n_start,
                        end_limit: n_end, limits_on: n_lim_on};
        end
    end

    always_comb begin
        case (idx)
            REG_FRAME_COUNT: prdata = {16'd0, r_fc};
            REG_START_LIMIT: prdata = {16'd0, r_start};
            REG_END_LIMIT:   prdata = {16'd0, r_end};
            REG_LIMITS_ON:   prdata = {31'd0, r_lim_on};
            REG_LOOP_ON:     prdata = {31'd0, r_loop_on};
            REG_PLAY_SPEED:  prdata = {16'd0, r_speed};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = '{frame_count: r_fc, start_limit: r_start, end_limit: r_end,
                     limits_on: r_lim_on, loop_on: r_loop_on, play_speed: r_speed};
    assign o_snap      = r_snap;
    assign o_lim_dirty = r_dirty;

endmodule
`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for the animation frame playhead.
`timescale 1ns / 1ps
module tb;
    import afp_pkg::*;

    // ------------------------------------------------------------------
    // Widths and limits of the playhead position (default build)
    // ------------------------------------------------------------------
    localparam int FB  = afp_pkg::FRAME_BITS_DEF;
    localparam int FRB = afp_pkg::FRACTION_BITS_DEF;
    localparam longint unsigned POS_MAX  = (64'd1 << (FB + FRB)) - 64'd1;
    localparam longint unsigned INT_MAX  = (64'd1 << FB) - 64'd1;
    localparam longint unsigned FRAC_MSK = (64'd1 << FRB) - 64'd1;

    // cycles with no transaction and no register write before the run is
    // declared hung; covers the long receiver hold plus a worst-case tick
    localparam int HANG_LIMIT   = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_TICKS  = 70;

    typedef struct {
        bit [15:0] frame_index;
        bit [15:0] next_frame_index;
        bit [15:0] blend_fraction;
        bit        at_end;
        bit        valid_res;
    } frame_result_t;

    // ------------------------------------------------------------------
    // DUT connections; every input known from time zero
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // [19:0] elapsed_time
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // [15:0] frame_index, [31:16] next_frame_index,
                                        // [47:32] blend_fraction, [48] at_end
    logic        m_axis_tuser;          // [0] valid_res
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    animation_frame_playhead_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    bit [19:0]     tick_q[$];       // elapsed-time ticks waiting to be offered
    frame_result_t frame_q[$];      // predicted frames, oldest first
    int            errors = 0;
    int            ticks_sent = 0;
    int            frames_seen = 0;
    int            cfg_writes = 0;
    int            src_idle_pct = 0;    // chance per cycle the sender idles
    int            snk_idle_pct = 0;    // chance per cycle the receiver stalls
    int            hold_left = 0;       // remaining cycles of a long receiver hold
    int            quiet_cycles = 0;

    // ------------------------------------------------------------------
    // Playhead predictor: own copy of the registers and cursor state
    // ------------------------------------------------------------------
    t_cfg            cur_cfg;
    longint unsigned play_pos;
    longint unsigned span_lo;       // effective first frame
    longint unsigned span_hi;       // effective last frame

    function automatic longint unsigned clip_frame(input longint unsigned v);
        return (v > INT_MAX) ? INT_MAX : v;
    endfunction

    // Effective range follows frame_count/limits; a zero count leaves it alone.
    function automatic void refresh_range();
        longint unsigned fc;
        fc = cur_cfg.frame_count;
        if (fc == 0)
            return;
        if (!cur_cfg.limits_on) begin
            span_lo = 0;
            span_hi = clip_frame(fc - 1);
        end else begin
            span_lo = clip_frame(64'(cur_cfg.start_limit) % fc);
            span_hi = clip_frame(64'(cur_cfg.end_limit) % fc);
        end
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_FRAME_COUNT: begin
                cur_cfg.frame_count = val[15:0];
                refresh_range();
            end
            REG_START_LIMIT: begin
                cur_cfg.start_limit = val[15:0];
                refresh_range();
            end
            REG_END_LIMIT: begin
                cur_cfg.end_limit = val[15:0];
                refresh_range();
            end
            REG_LIMITS_ON: begin
                cur_cfg.limits_on = val[0];
                refresh_range();
            end
            REG_LOOP_ON:    cur_cfg.loop_on = val[0];
            REG_PLAY_SPEED: cur_cfg.play_speed = val[15:0];
            default: ;
        endcase
    endfunction

    // One tick: advance, wrap or clamp, then derive the reported frames.
    function automatic frame_result_t advance_playhead(input bit [19:0] dt);
        longint unsigned prod, inc, p, end_fx, start_fx, span_fx, ip, frac, nxt;
        bit clamped;
        frame_result_t r;
        prod = cur_cfg.play_speed;
        prod = prod * dt;                   // 12.24 seconds*frames
        inc = (prod << FRB) >> 24;
        p = play_pos + inc;
        end_fx = span_hi << FRB;
        start_fx = span_lo << FRB;
        span_fx = (span_hi > span_lo) ? (span_hi - span_lo) << FRB : 64'd0;
        clamped = 1'b0;
        if (p > POS_MAX)
            p = POS_MAX;
        if (p >= end_fx) begin
            if (cur_cfg.loop_on)
                p = (span_fx != 0) ? start_fx + (p - end_fx) % span_fx : start_fx;
            else begin
                p = end_fx;
                clamped = 1'b1;
            end
        end
        if (p > POS_MAX)
            p = POS_MAX;
        play_pos = p;

        r = '{default: 0};
        if (cur_cfg.frame_count == 0)
            return r;

        ip = p >> FRB;
        frac = p & FRAC_MSK;
        nxt = ip + ((frac != 0) ? 64'd1 : 64'd0);
        if (nxt >= 64'(cur_cfg.frame_count))
            nxt = (span_fx != 0) ? span_lo + ((p % span_fx) >> FRB) : span_lo;
        r.frame_index      = ip[15:0];
        r.next_frame_index = nxt[15:0];
        r.blend_fraction   = 16'(((frac << 16) >> FRB) & 64'hFFFF);
        r.at_end           = clamped;
        r.valid_res        = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers ticks from tick_q, predicts on every accepted one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                frame_q.push_back(advance_playhead(s_axis_tdata[19:0]));
                ticks_sent++;
            end
            // hold the current transaction until taken; one NBA per signal
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_axis_tdata  <= {4'b0, tick_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each frame against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        frame_result_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                frames_seen++;
                if (frame_q.size() == 0) begin
                    $display("%0t: unexpected frame, expected none, actual %h/%b",
                             $time, m_axis_tdata, m_axis_tuser);
                    errors++;
                end else begin
                    want = frame_q.pop_front();
                    check_field("frame_index", want.frame_index, m_axis_tdata[15:0]);
                    check_field("next_frame_index", want.next_frame_index,
                                m_axis_tdata[31:16]);
                    check_field("blend_fraction", want.blend_fraction, m_axis_tdata[47:32]);
                    check_field("at_end", 16'(want.at_end), 16'(m_axis_tdata[48]));
                    check_field("valid_res", 16'(want.valid_res), 16'(m_axis_tuser));
                end
            end
            // long back-pressure bursts so the block fills and stalls its input
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready &&
                         (frames_seen == 150 || frames_seen == 620)) begin
                hold_left <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transaction of any kind
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d frames outstanding",
                     $time, HANG_LIMIT, frame_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // APB write: setup cycle, then access cycle; pready is tied high
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        apply_reg(idx, val);
        cfg_writes++;
    endtask

    // wait until every tick is taken and every frame returned
    task automatic settle();
        while (tick_q.size() != 0 || s_axis_tvalid || frame_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic bit [19:0] pick_tick();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return 20'($urandom_range(0, 'h1000));     // typical frame times
        else if (roll < 45)
            return 20'h00000;
        else if (roll < 50)
            return 20'hFFFFF;
        else
            return 20'($urandom);
    endfunction

    function automatic logic [15:0] pick_extreme16(input int lo_max);
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 16'd0;
        else if (roll < 20)
            return 16'hFFFF;
        else if (roll < 30)
            return 16'd1;
        else if (roll < 65)
            return 16'($urandom_range(2, lo_max));
        else
            return 16'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        logic [31:0] val;
        logic [2:0]  idx;
        int          rot;

        cur_cfg = '0;
        cur_cfg.play_speed = SPEED_RESET;
        play_pos = 0;
        span_lo = 0;
        span_hi = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ----
        src_idle_pct = 29;
        snk_idle_pct = 60;

        // no clip loaded: cursor clamps at zero, all fields zero
        tick_q.push_back(20'h00000);
        tick_q.push_back(20'hFFFFF);
        tick_q.push_back(20'h00001);
        settle();

        // single-frame clip, looping: empty span falls back to range start
        reg_write(REG_FRAME_COUNT, 32'd1);
        reg_write(REG_LOOP_ON, 32'd1);
        tick_q.push_back(20'h01000);
        tick_q.push_back(20'hFFFFF);
        settle();

        // 100-frame clip at 30 fps, looping across the whole clip
        reg_write(REG_FRAME_COUNT, 32'd100);
        tick_q.push_back(20'h00889);
        tick_q.push_back(20'hFFFFF);
        tick_q.push_back(20'h01234);
        settle();

        // hold at end: clamp flag, then clamp again with zero elapsed time
        reg_write(REG_LOOP_ON, 32'd0);
        tick_q.push_back(20'hFFFFF);
        tick_q.push_back(20'h00000);
        settle();

        // limits on with a reversed span (start 50, end 30 after modulo)
        reg_write(REG_START_LIMIT, 32'd250);
        reg_write(REG_END_LIMIT, 32'd130);
        reg_write(REG_LIMITS_ON, 32'd1);
        reg_write(REG_LOOP_ON, 32'd1);
        tick_q.push_back(20'h08000);
        tick_q.push_back(20'h00001);
        settle();
        reg_write(REG_LOOP_ON, 32'd0);
        tick_q.push_back(20'h00400);
        settle();

        // start and end land on the same frame: zero span
        reg_write(REG_START_LIMIT, 32'd17);
        reg_write(REG_END_LIMIT, 32'd117);
        reg_write(REG_LOOP_ON, 32'd1);
        tick_q.push_back(20'h00800);
        tick_q.push_back(20'hFFFFF);
        settle();

        // largest clip, full speed, holding: position saturates then clamps
        reg_write(REG_LIMITS_ON, 32'd0);
        reg_write(REG_FRAME_COUNT, 32'd65535);
        reg_write(REG_LOOP_ON, 32'd0);
        reg_write(REG_PLAY_SPEED, 32'hFFFF);
        repeat (3) tick_q.push_back(20'hFFFFF);
        settle();
        reg_write(REG_LOOP_ON, 32'd1);
        tick_q.push_back(20'hFFFFF);
        tick_q.push_back(20'h7FFFF);
        settle();
        reg_write(REG_PLAY_SPEED, 32'd0);
        tick_q.push_back(20'hFFFFF);
        settle();

        // ---- random phases ----
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            // receiver-heavy idling, then sender-heavy, then none at all
            if (ph < RAND_PHASES / 3) begin
                src_idle_pct = 29;
                snk_idle_pct = 60;
            end else if (ph < 2 * RAND_PHASES / 3) begin
                src_idle_pct = 60;
                snk_idle_pct = 29;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            // rewrite the registers in a rotating order; upper bus bits are noise
            rot = $urandom_range(5);
            for (int k = 0; k < 6; k++) begin
                idx = 3'((k + rot) % 6);
                if (ph != 0 && $urandom_range(99) < 25)
                    continue;
                val = $urandom;
                case (idx)
                    REG_FRAME_COUNT: val[15:0] = pick_extreme16(300);
                    REG_START_LIMIT,
                    REG_END_LIMIT:   val[15:0] = pick_extreme16(400);
                    REG_PLAY_SPEED:  val[15:0] = pick_extreme16(16'h4000);
                    default: ;      // single-bit registers take bit 0
                endcase
                reg_write(idx, val);
            end

            for (int n = 0; n < PHASE_TICKS; n++)
                tick_q.push_back(pick_tick());
            settle();
        end

        // ---- drain ----
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (frame_q.size() != 0) begin
            $display("%0t: %0d predicted frames never arrived", $time, frame_q.size());
            errors++;
        end

        $display("Run covered %0d ticks and %0d frames over %0d register writes,",
                 ticks_sent, frames_seen, cfg_writes);
        $display("with looping, holding, limit ranges, empty clips and back-pressure.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
